### hdl/sftb_pkg.sv
package sftb_pkg;

    localparam int FLASH_BYTES = 262144;
    localparam int FLASH_AW    = $clog2(FLASH_BYTES);

    localparam logic [7:0] CMD_READ   = 8'h03;
    localparam logic [7:0] CMD_STATUS = 8'h05;

    localparam logic [1:0] DEV_POWER = 2'd0;
    localparam logic [1:0] DEV_FLASH = 2'd1;
    localparam logic [1:0] DEV_TOUCH = 2'd2;
    localparam logic [1:0] DEV_RSVD  = 2'd3;

    localparam logic [2:0] REG_ADC_LEFT      = 3'd0;
    localparam logic [2:0] REG_ADC_TOP       = 3'd1;
    localparam logic [2:0] REG_SCREEN_LEFT   = 3'd2;
    localparam logic [2:0] REG_SCREEN_TOP    = 3'd3;
    localparam logic [2:0] REG_ADC_RIGHT     = 3'd4;
    localparam logic [2:0] REG_ADC_BOTTOM    = 3'd5;
    localparam logic [2:0] REG_SCREEN_RIGHT  = 3'd6;
    localparam logic [2:0] REG_SCREEN_BOTTOM = 3'd7;

    localparam logic [2:0] TCH_CH_Y = 3'd1;
    localparam logic [2:0] TCH_CH_X = 3'd5;

    localparam int DIV_STEPS = 22;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [17:0] preload_addr;
        logic        bus_enable;
        logic [1:0]  device_sel;
        logic        hold_select;
        logic        irq_enable;
        logic        halfword_mode;
        logic        pen_down;
        logic [7:0]  pen_x;
        logic [7:0]  pen_y;
    } t_in_word;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_pulse;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture item, start work
        logic div_start;  // launch divider
        logic div_step;   // one restoring step
        logic commit;     // update state, build result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_sts;

endpackage

### hdl/sftb_ram.sv
module sftb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/sftb_ctrl.sv
module sftb_ctrl
    import sftb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;  // wait for RAM read / setup
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                if (i_sts.need_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.commit = 1'b1;
                n_state      = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("ready while result pending");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> o_in_ready) else $error("load outside idle");
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> o_out_valid) else $error("commit not followed by result");
`endif

endmodule

### hdl/sftb_dp.sv
module sftb_dp
    import sftb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_in,
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  t_cmd       i_cmd,
    output t_sts       o_sts,
    output t_out_word  o_out
);

    logic [11:0] r_adc_left, r_adc_top, r_adc_right, r_adc_bottom;
    logic [7:0]  r_scr_left, r_scr_top, r_scr_right, r_scr_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_left   <= 12'd0;
            r_adc_top    <= 12'd0;
            r_scr_left   <= 8'd0;
            r_scr_top    <= 8'd0;
            r_adc_right  <= 12'd4095;
            r_adc_bottom <= 12'd4095;
            r_scr_right  <= 8'd255;
            r_scr_bottom <= 8'd191;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ADC_LEFT:      r_adc_left   <= i_cfg_data;
                REG_ADC_TOP:       r_adc_top    <= i_cfg_data;
                REG_SCREEN_LEFT:   r_scr_left   <= i_cfg_data[7:0];
                REG_SCREEN_TOP:    r_scr_top    <= i_cfg_data[7:0];
                REG_ADC_RIGHT:     r_adc_right  <= i_cfg_data;
                REG_ADC_BOTTOM:    r_adc_bottom <= i_cfg_data;
                REG_SCREEN_RIGHT:  r_scr_right  <= i_cfg_data[7:0];
                REG_SCREEN_BOTTOM: r_scr_bottom <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // captured item
    t_in_word r_item;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in;
        end
    end

    logic [2:0]  r_byte_index;
    logic [7:0]  r_cmd_reg;
    logic [23:0] r_flash_ptr;
    logic [15:0] r_shift;
    logic [7:0]  r_data;
    logic        r_irq;

    // flash store: read at the pointer, data ready in the cycle after load
    logic             ram_we;
    logic [FLASH_AW-1:0] ram_rdata_addr;
    logic [7:0]       ram_rdata;
    assign ram_we = i_cmd.load && i_in.req_type
                    && (32'(i_in.preload_addr) < 32'(FLASH_BYTES));
    assign ram_rdata_addr = r_flash_ptr[FLASH_AW-1:0];

    sftb_ram #(.WIDTH(8), .DEPTH(FLASH_BYTES)) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(i_in.preload_addr[FLASH_AW-1:0]),
        .i_wdata(i_in.data_byte),
        .i_raddr(ram_rdata_addr),
        .o_rdata(ram_rdata)
    );

    // touch channel decode
    logic [2:0] chan;
    logic       tch_go, tch_y;
    assign chan   = r_item.data_byte[6:4];
    assign tch_go = r_item.data_byte[7] && r_item.pen_down
                    && (chan == TCH_CH_Y || chan == TCH_CH_X);
    assign tch_y  = (chan == TCH_CH_Y);

    logic [7:0]  s1, s2, pos;
    logic [11:0] a1, a2;
    assign s1  = tch_y ? r_scr_top    : r_scr_left;
    assign s2  = tch_y ? r_scr_bottom : r_scr_right;
    assign a1  = tch_y ? r_adc_top    : r_adc_left;
    assign a2  = tch_y ? r_adc_bottom : r_adc_right;
    assign pos = tch_y ? r_item.pen_y : r_item.pen_x;

    logic signed [8:0]  span;
    logic signed [9:0]  dpos;
    logic signed [12:0] dadc;
    logic signed [22:0] prod;
    assign span = $signed({1'b0, s2}) - $signed({1'b0, s1});
    assign dpos = $signed({2'b0, pos}) - $signed({2'b0, s1}) + 10'sd1;
    assign dadc = $signed({1'b0, a2}) - $signed({1'b0, a1});
    assign prod = $signed(23'(dpos)) * $signed(23'(dadc));

    logic is_touch_data;
    assign is_touch_data = !r_item.req_type && r_item.bus_enable && (r_byte_index != 3'd0)
                           && (r_item.device_sel == DEV_TOUCH) && tch_go;

    assign o_sts.need_div = is_touch_data && (span != 9'sd0);

    // restoring divider on magnitudes, one quotient bit per step
    logic [21:0] r_rem_q;    // dividend shifts out, quotient shifts in
    logic [8:0]  r_rem;
    logic [7:0]  r_dvs;
    logic        r_neg;
    logic [4:0]  r_cnt;
    logic [9:0]  trial;
    logic [8:0]  rem_sh;

    assign rem_sh = {r_rem[7:0], r_rem_q[21]};
    assign trial  = {1'b0, rem_sh} - {2'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem_q <= prod[22] ? 22'(-prod) : prod[21:0];
            r_rem   <= 9'd0;
            r_dvs   <= span[8] ? 8'(-span) : span[7:0];
            r_neg   <= prod[22] ^ span[8];
            r_cnt   <= 5'd0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 5'd1;
            if (!trial[9]) begin
                r_rem   <= trial[8:0];
                r_rem_q <= {r_rem_q[20:0], 1'b1};
            end else begin
                r_rem   <= rem_sh;
                r_rem_q <= {r_rem_q[20:0], 1'b0};
            end
        end
    end

    assign o_sts.div_last = (r_cnt == 5'(DIV_STEPS - 1));

    logic [15:0] quo;
    logic [15:0] axis;
    assign quo  = r_neg ? 16'(-r_rem_q) : r_rem_q[15:0];
    assign axis = (span == 9'sd0) ? {4'd0, a1} : 16'(quo + {4'd0, a1});

    // state update
    logic [2:0]  n_byte_index;
    logic [7:0]  n_cmd_reg, n_data;
    logic [23:0] n_flash_ptr;
    logic [15:0] n_shift;
    logic        n_irq;

    always_comb begin
        n_byte_index = r_byte_index;
        n_cmd_reg    = r_cmd_reg;
        n_flash_ptr  = r_flash_ptr;
        n_shift      = r_shift;
        n_data       = r_data;
        n_irq        = 1'b0;
        if (r_item.req_type) begin
            n_data = r_data;
        end else if (!r_item.bus_enable) begin
            n_data = 8'd0;
        end else begin
            if (r_byte_index == 3'd0) begin
                n_cmd_reg   = r_item.data_byte;
                n_flash_ptr = 24'd0;
                n_data      = 8'd0;
            end else begin
                unique case (r_item.device_sel)
                    DEV_POWER: n_data = 8'd0;
                    DEV_FLASH: begin
                        if (r_cmd_reg == CMD_READ) begin
                            if (r_byte_index < 3'd4) begin
                                unique case (r_byte_index)
                                    3'd1: n_flash_ptr = r_flash_ptr | {r_item.data_byte, 16'd0};
                                    3'd2: n_flash_ptr = r_flash_ptr | {8'd0, r_item.data_byte, 8'd0};
                                    default: n_flash_ptr = r_flash_ptr | {16'd0, r_item.data_byte};
                                endcase
                            end else begin
                                n_data      = ram_rdata;
                                n_flash_ptr = r_flash_ptr + (r_item.halfword_mode ? 24'd2 : 24'd1);
                            end
                        end else if (r_cmd_reg == CMD_STATUS) begin
                            n_data = 8'd0;
                        end
                    end
                    DEV_TOUCH: begin
                        n_data  = r_shift[15:8];
                        n_shift = tch_go ? {axis[12:0], 3'd0} : {r_shift[7:0], 8'd0};
                    end
                    DEV_RSVD: ;
                    default: ;
                endcase
            end
            if (r_item.hold_select) begin
                if (r_byte_index != 3'd7) begin
                    n_byte_index = r_byte_index + 3'd1;
                end
            end else begin
                n_byte_index = 3'd0;
            end
            n_irq = r_item.irq_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_index <= 3'd0;
            r_cmd_reg    <= 8'd0;
            r_flash_ptr  <= 24'd0;
            r_shift      <= 16'd0;
            r_data       <= 8'd0;
            r_irq        <= 1'b0;
        end else if (i_cmd.commit) begin
            r_byte_index <= n_byte_index;
            r_cmd_reg    <= n_cmd_reg;
            r_flash_ptr  <= n_flash_ptr;
            r_shift      <= n_shift;
            r_data       <= n_data;
            r_irq        <= n_irq;
        end
    end

    assign o_out.read_data = r_data;
    assign o_out.irq_pulse = r_irq;

`ifndef SYNTHESIS
    a_div_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_cnt < 5'(DIV_STEPS)) else $error("divider overrun");
    a_preload_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_item.req_type |=> !r_irq) else $error("irq on preload");
    a_disabled_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && !r_item.req_type && !r_item.bus_enable |=> r_data == 8'd0)
        else $error("disabled bus left data");
`endif

endmodule

### hdl/spi_flash_touch_bus_top.sv
// SPI byte exchanger for flash, touchscreen converter and power device. One input
// word at a time: a flash preload or plain exchange passes the read, done and output
// states, ending with the result handshake and the return to idle; a touch conversion
// with a nonzero calibration span also runs the 22-step restoring divider between the
// read and done states. A stalled receiver holds the block in the output state. The
// flash store is a single-port-write RAM with a registered read, read at the current
// flash pointer. Calibration registers are to be written through the config channel
// only while the block is idle; the block itself does not enforce this.
module spi_flash_touch_bus_top
    import sftb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    sftb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    sftb_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in_data),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out_data)
    );

endmodule

### tb/tb_spi_flash_touch_bus_top.sv
module tb_spi_flash_touch_bus_top;
    import sftb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_data;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [11:0] i_cfg_data;

    spi_flash_touch_bus_top dut (.*);

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // predictor state
    logic [11:0] cal_adc_l, cal_adc_t, cal_adc_r, cal_adc_b;
    logic [7:0]  cal_scr_l, cal_scr_t, cal_scr_r, cal_scr_b;
    logic [2:0]  xfer_pos;
    logic [7:0]  cur_cmd;
    logic [23:0] flash_ptr;
    logic [15:0] touch_shift;
    logic [7:0]  spi_data;
    logic [7:0]  flash_mem [logic [17:0]];

    t_out_word   expected_words[$];
    int          mismatches;
    longint      cycle_count;
    bit          rx_hold;
    int          rx_hold_cycles;

    // last preloaded address and how far reads may safely go from it
    logic [17:0] flash_base;
    int          flash_len;

    function automatic logic [15:0] map_axis(logic [7:0] pos, logic [7:0] s1, logic [7:0] s2,
                                             logic [11:0] a1, logic [11:0] a2);
        int span;
        int v;
        span = int'(s2) - int'(s1);
        if (span == 0)
            v = int'(a1);
        else
            v = (int'(pos) - int'(s1) + 1) * (int'(a2) - int'(a1)) / span + int'(a1);
        return v[15:0];
    endfunction

    task automatic predict_word(input t_in_word w);
        logic [7:0] upper;
        logic [15:0] cnt;
        logic [2:0] ch;
        t_out_word r;
        r.irq_pulse = 1'b0;
        if (w.req_type) begin
            flash_mem[w.preload_addr] = w.data_byte;
        end else if (!w.bus_enable) begin
            spi_data = 8'h00;
        end else begin
            if (xfer_pos == 3'd0) begin
                cur_cmd = w.data_byte;
                flash_ptr = '0;
                spi_data = 8'h00;
            end else begin
                case (w.device_sel)
                    DEV_POWER: spi_data = 8'h00;
                    DEV_FLASH: begin
                        if (cur_cmd == CMD_READ) begin
                            if (xfer_pos < 3'd4) begin
                                flash_ptr = flash_ptr |
                                    (24'(w.data_byte) << ((3 - xfer_pos) * 8));
                            end else begin
                                spi_data = flash_mem.exists(flash_ptr[17:0]) ?
                                           flash_mem[flash_ptr[17:0]] : 8'h00;
                                flash_ptr = flash_ptr + (w.halfword_mode ? 24'd2 : 24'd1);
                            end
                        end else if (cur_cmd == CMD_STATUS) begin
                            spi_data = 8'h00;
                        end
                    end
                    DEV_TOUCH: begin
                        upper = touch_shift[15:8];
                        touch_shift = {touch_shift[7:0], 8'h00};
                        if (w.data_byte[7] && w.pen_down) begin
                            ch = w.data_byte[6:4];
                            if (ch == TCH_CH_Y) begin
                                cnt = map_axis(w.pen_y, cal_scr_t, cal_scr_b, cal_adc_t, cal_adc_b);
                                touch_shift = cnt << 3;
                            end else if (ch == TCH_CH_X) begin
                                cnt = map_axis(w.pen_x, cal_scr_l, cal_scr_r, cal_adc_l, cal_adc_r);
                                touch_shift = cnt << 3;
                            end
                        end
                        spi_data = upper;
                    end
                    default: ;
                endcase
            end
            if (w.hold_select) begin
                if (xfer_pos < 3'd7)
                    xfer_pos = xfer_pos + 3'd1;
            end else begin
                xfer_pos = 3'd0;
            end
            r.irq_pulse = w.irq_enable;
        end
        r.read_data = spi_data;
        expected_words.push_back(r);
    endtask

    // response checker and receiver stalls
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, o_out_data);
                mismatches++;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                if (e.read_data !== o_out_data.read_data) begin
                    $display("%0t: read_data expected %h actual %h", $time, e.read_data,
                             o_out_data.read_data);
                    mismatches++;
                end
                if (e.irq_pulse !== o_out_data.irq_pulse) begin
                    $display("%0t: irq_pulse expected %b actual %b", $time, e.irq_pulse,
                             o_out_data.irq_pulse);
                    mismatches++;
                end
            end
        end
    end

    int rx_wait;
    always @(negedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            rx_hold_cycles--;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready) begin
            rx_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            i_out_ready <= (rx_wait == 0);
        end else if (!i_out_ready) begin
            if (rx_wait > 0) rx_wait--;
            i_out_ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    bit burst_mode;

    // valid stays high into the next word when there is no gap; drain drops it
    task automatic send_word(input t_in_word w);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 12);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_word(w);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_ADC_LEFT:      cal_adc_l = val;
            REG_ADC_TOP:       cal_adc_t = val;
            REG_SCREEN_LEFT:   cal_scr_l = val[7:0];
            REG_SCREEN_TOP:    cal_scr_t = val[7:0];
            REG_ADC_RIGHT:     cal_adc_r = val;
            REG_ADC_BOTTOM:    cal_adc_b = val;
            REG_SCREEN_RIGHT:  cal_scr_r = val[7:0];
            default:           cal_scr_b = val[7:0];
        endcase
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    function automatic t_in_word rand_word();
        t_in_word w;
        w = t_in_word'({$urandom, $urandom});
        w.req_type = 1'b0;
        w.pen_y = $urandom_range(0, 191);
        return w;
    endfunction

    function automatic t_in_word xfer(input logic [1:0] dev, input logic [7:0] b,
                                      input logic hold);
        t_in_word w;
        w = rand_word();
        w.bus_enable = 1'b1;
        w.device_sel = dev;
        w.data_byte = b;
        w.hold_select = hold;
        return w;
    endfunction

    task automatic preload(input logic [17:0] a, input logic [7:0] b);
        t_in_word w;
        w = rand_word();
        w.req_type = 1'b1;
        w.preload_addr = a;
        w.data_byte = b;
        send_word(w);
    endtask

    // command byte, three address bytes, then n data bytes
    task automatic flash_read(input logic [23:0] a, input int n);
        int k;
        send_word(xfer(DEV_FLASH, CMD_READ, 1'b1));
        send_word(xfer(DEV_FLASH, a[23:16], 1'b1));
        send_word(xfer(DEV_FLASH, a[15:8], 1'b1));
        send_word(xfer(DEV_FLASH, a[7:0], 1'b1));
        for (k = 0; k < n; k++)
            send_word(xfer(DEV_FLASH, $urandom, k != n - 1));
    endtask

    task automatic test_directed;
        t_in_word w;
        int k;
        for (k = 0; k < 8; k++) preload(18'h3FFF8 + k, $urandom);
        preload(18'h00000, 8'hFF);
        preload(18'h00001, 8'h00);
        // reads near the top of the store, one with address bits above its width, halfword and byte steps
        flash_read(24'hFFFFF8, 3);
        flash_read(24'h03FFF8, 2);
        send_word(xfer(DEV_FLASH, CMD_STATUS, 1'b1));
        send_word(xfer(DEV_FLASH, 8'h5A, 1'b0));
        send_word(xfer(DEV_POWER, 8'h00, 1'b1));
        send_word(xfer(DEV_POWER, 8'hFF, 1'b0));
        send_word(xfer(DEV_RSVD, 8'hFF, 1'b1));
        send_word(xfer(DEV_RSVD, 8'hAA, 1'b0));
        w = xfer(DEV_FLASH, 8'h12, 1'b1);
        w.bus_enable = 1'b0;
        send_word(w);
        send_word(xfer(DEV_TOUCH, 8'hD0, 1'b1));
        w = xfer(DEV_TOUCH, 8'h90, 1'b1);
        w.pen_down = 1'b1; w.pen_x = 8'hFF; w.pen_y = 8'd191;
        send_word(w);
        send_word(xfer(DEV_TOUCH, 8'h00, 1'b1));
        send_word(xfer(DEV_TOUCH, 8'h00, 1'b0));
        drain();
    endtask

    task automatic touch_seq(input int n);
        t_in_word w;
        int k;
        send_word(xfer(DEV_TOUCH, $urandom, 1'b1));
        for (k = 0; k < n; k++) begin
            w = xfer(DEV_TOUCH, $urandom, k != n - 1);
            if ($urandom_range(0, 3) != 0) begin
                w.data_byte[7] = 1'b1;
                w.data_byte[6:4] = $urandom_range(0, 1) ? TCH_CH_X : TCH_CH_Y;
                w.pen_down = ($urandom_range(0, 7) != 0);
            end
            send_word(w);
        end
    endtask

    task automatic test_touch(input int n_seq);
        int s;
        for (s = 0; s < n_seq; s++) touch_seq($urandom_range(1, 6));
        drain();
    endtask

    task automatic calibrate(input logic [11:0] al, at, ar, ab,
                             input logic [7:0] sl, st, sr, sb);
        write_reg(REG_ADC_LEFT, al);
        write_reg(REG_ADC_TOP, at);
        write_reg(REG_SCREEN_LEFT, {4'h0, sl});
        write_reg(REG_SCREEN_TOP, {4'h0, st});
        write_reg(REG_ADC_RIGHT, ar);
        write_reg(REG_ADC_BOTTOM, ab);
        write_reg(REG_SCREEN_RIGHT, {4'h0, sr});
        write_reg(REG_SCREEN_BOTTOM, {4'h0, sb});
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_calibration;
        calibrate(12'hFFF, 12'hFFF, 12'h000, 12'h000, 8'hFF, 8'hBF, 8'h00, 8'h00);
        test_touch(8);
        // zero spans
        calibrate(12'h123, 12'hABC, 12'hFFF, 12'h000, 8'h40, 8'h40, 8'h40, 8'h40);
        test_touch(5);
        calibrate($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
        test_touch(10);
    endtask

    // reads only from a region that was preloaded
    task automatic test_random(input int n_items);
        t_in_word w;
        int sent;
        int k;
        int n;
        int choice;
        sent = 0;
        while (sent < n_items) begin
            choice = $urandom_range(0, 9);
            if (choice < 4) begin
                flash_base = $urandom;
                flash_len = 24;
                for (k = 0; k < flash_len; k++) preload(flash_base + k, $urandom);
                n = $urandom_range(1, 8);
                flash_read({6'h0, flash_base}, n);
                sent += flash_len + 4 + n;
            end else if (choice < 7) begin
                n = $urandom_range(1, 6);
                touch_seq(n);
                sent += n + 1;
            end else begin
                // noise that never reaches flash data
                w = rand_word();
                if (w.device_sel == DEV_FLASH) w.device_sel = DEV_POWER;
                if ($urandom_range(0, 4) == 0) w.bus_enable = 1'b0;
                send_word(w);
                w = xfer(DEV_FLASH, $urandom, 1'b0);
                if (w.data_byte == CMD_READ) w.data_byte = CMD_STATUS;
                send_word(w);
                sent += 2;
            end
        end
        drain();
    endtask

    task automatic test_backpressure;
        int k;
        fork
            rx_hold_cycles = 300;
            begin
                burst_mode = 1'b1;
                for (k = 0; k < 20; k++) send_word(xfer(DEV_POWER, $urandom, 1'b0));
                burst_mode = 1'b0;
            end
        join
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        mismatches = 0;
        cycle_count = 0;
        rx_hold_cycles = 0;
        rx_wait = 0;
        burst_mode = 1'b0;
        cal_adc_l = 0; cal_adc_t = 0; cal_scr_l = 0; cal_scr_t = 0;
        cal_adc_r = 12'hFFF; cal_adc_b = 12'hFFF; cal_scr_r = 8'hFF; cal_scr_b = 8'd191;
        xfer_pos = 0; cur_cmd = 0; flash_ptr = 0; touch_shift = 0; spi_data = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_touch(10);
        test_backpressure();
        test_calibration();
        test_random(600);
        drain();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
